@@ hdl/lztr_pkg.sv @@
package lztr_pkg;

    // item opcodes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_LITERAL = 2'd1;
    localparam logic [1:0] OP_MATCH   = 2'd2;

    // offset selector decoding
    localparam logic [16:0] SEL_REP_LIMIT = 17'd4;
    localparam logic [16:0] NEW_OFFS_BIAS = 17'd3;
    localparam logic [15:0] OFFS_SAT      = 16'hffff;
    localparam logic [15:0] REP_RESET     = 16'd1;

    // match length bonus thresholds and bases
    localparam logic [15:0] BONUS_SMALL  = 16'h04ff;
    localparam logic [15:0] BONUS_LARGE  = 16'h63ff;
    localparam logic [6:0]  LEN_BASE_REP = 7'd2;
    localparam logic [6:0]  LEN_BASE_NEW = 7'd4;

    // shared adder operation
    typedef enum logic [1:0] {
        ALU_ADD = 2'b01,
        ALU_SUB = 2'b10
    } alu_op_t;

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_LIT    = 8'b0000_0010,
        ST_OFFS   = 8'b0000_0100,
        ST_REDUCE = 8'b0000_1000,
        ST_ADDR   = 8'b0001_0000,
        ST_WRAP   = 8'b0010_0000,
        ST_READ   = 8'b0100_0000,
        ST_DATA   = 8'b1000_0000
    } state_t;

endpackage

@@ hdl/lztr_ram.sv @@
module lztr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lztr_alu.sv @@
module lztr_alu #(
    parameter int W = 17
) (
    input  lztr_pkg::alu_op_t op,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic [W-1:0]      y,
    output logic              borrow
);

    logic [W:0] full;

    // add or subtract with carry out, top bit flags a borrow on subtract
    always_comb begin
        unique case (op)
            lztr_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
            lztr_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
            default:           full = '0;
        endcase
    end

    assign y      = full[W-1:0];
    assign borrow = full[W];

endmodule

@@ hdl/lz_token_reconstruct_rep4.sv @@
// LZ token reconstruction with four move-to-front repeat offsets.
// Input channel s_*: one token per transaction (start chunk, literal, match).
// Output channel m_*: one reconstructed byte per transaction, with flags for
// the last byte of a token and the byte that completes the chunk.
// The block takes one token at a time; s_ready is high only while the
// sequencer waits for a token.
// Start items and ignored items finish in the accept state. A literal is
// accepted, then written and emitted from the literal state. A match steps
// through offset decode, one pass of the offset reduction per WINDOW_SIZE the
// offset spans (none at the default window), address and, when the source
// wraps, a wrap state; the history RAM has a registered read port, so each
// copied byte is a read state followed by a write/emit state.
// Offset decode, offset reduction and source address arithmetic run through one shared adder.
// A byte waits in the output register while m_ready is low; the sequencer
// holds in its emit state until the register frees up.
// Reset (aresetn, synchronous) clears position, limit and write pointer and
// sets the repeat offsets to one; the history RAM is not cleared.
module lz_token_reconstruct_rep4 #(
    parameter int WINDOW_SIZE = 65536,
    parameter int MAX_CHUNK   = 32768,
    parameter int MAX_MATCH   = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [15:0] s_chunk_size,
    input  logic [7:0]  s_literal_byte,
    input  logic [16:0] s_offset_select,
    input  logic [5:0]  s_length_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_item,
    output logic        m_chunk_full
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int DW = (AW + 1 > 17) ? AW + 1 : 17;
    localparam int CW = $clog2(MAX_CHUNK + 1);
    localparam int LW = $clog2(MAX_MATCH + 1);
    localparam logic [DW-1:0] WIN_D   = DW'(WINDOW_SIZE);
    localparam logic [AW-1:0] WIN_TOP = AW'(WINDOW_SIZE - 1);

    // control state
    lztr_pkg::state_t state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [15:0]   rep_reg [4];
    logic [15:0]   rep_next [4];
    logic          m_valid_reg, m_valid_next;

    // working registers
    logic [7:0]    lit_reg, lit_next;
    logic [16:0]   sel_reg, sel_next;
    logic [5:0]    raw_reg, raw_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] work_reg, work_next;
    logic [AW-1:0] src_reg, src_next;
    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;
    logic          full_reg, full_next;

    // shared adder and history memory
    lztr_pkg::alu_op_t alu_op;
    logic [DW-1:0] alu_a, alu_b, alu_y;
    logic          alu_borrow;
    logic          ram_we, ram_re;
    logic [7:0]    ram_wdata, ram_rdata;

    // helpers
    logic          slot_free, active, full_hit, last_hit;
    logic [AW-1:0] wp_inc, src_inc;
    logic [CW-1:0] pos_inc;
    logic [LW-1:0] cnt_inc;
    logic [15:0]   dist16;
    logic [6:0]    len7;

    lztr_alu #(.W(DW)) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .y      (alu_y),
        .borrow (alu_borrow)
    );

    lztr_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_history (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign active    = pos_reg < limit_reg;
    assign wp_inc    = (wp_reg == WIN_TOP) ? '0 : wp_reg + 1'b1;
    assign src_inc   = (src_reg == WIN_TOP) ? '0 : src_reg + 1'b1;
    assign pos_inc   = pos_reg + 1'b1;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign full_hit  = pos_inc == limit_reg;
    assign last_hit  = (cnt_inc == len_reg) || full_hit;

    // sequencer next-state and datapath
    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        pos_next     = pos_reg;
        limit_next   = limit_reg;
        rep_next     = rep_reg;
        m_valid_next = m_valid_reg && !m_ready;
        lit_next     = lit_reg;
        sel_next     = sel_reg;
        raw_next     = raw_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        work_next    = work_reg;
        src_next     = src_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        full_next    = full_reg;
        alu_op       = lztr_pkg::ALU_SUB;
        alu_a        = '0;
        alu_b        = '0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = lit_reg;
        dist16       = '0;
        len7         = '0;

        unique case (state_reg)
            lztr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    lit_next = s_literal_byte;
                    sel_next = s_offset_select;
                    raw_next = s_length_code;
                    unique case (s_opcode)
                        lztr_pkg::OP_START: begin
                            limit_next = (32'(s_chunk_size) > 32'(MAX_CHUNK)) ?
                                         CW'(MAX_CHUNK) : CW'(s_chunk_size);
                            pos_next   = '0;
                            for (int i = 0; i < 4; i++) begin
                                rep_next[i] = lztr_pkg::REP_RESET;
                            end
                        end
                        lztr_pkg::OP_LITERAL: begin
                            if (active) begin
                                state_next = lztr_pkg::ST_LIT;
                            end
                        end
                        lztr_pkg::OP_MATCH: begin
                            if (active) begin
                                state_next = lztr_pkg::ST_OFFS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lztr_pkg::ST_LIT: begin
                if (slot_free) begin
                    ram_we       = 1'b1;
                    ram_wdata    = lit_reg;
                    m_valid_next = 1'b1;
                    byte_next    = lit_reg;
                    last_next    = 1'b1;
                    full_next    = full_hit;
                    wp_next      = wp_inc;
                    pos_next     = pos_inc;
                    state_next   = lztr_pkg::ST_IDLE;
                end
            end
            lztr_pkg::ST_OFFS: begin
                // decode distance and length, update the repeat offsets
                alu_a = DW'(sel_reg);
                alu_b = DW'(lztr_pkg::NEW_OFFS_BIAS);
                if (sel_reg >= lztr_pkg::SEL_REP_LIMIT) begin
                    dist16 = (alu_y > DW'(lztr_pkg::OFFS_SAT)) ?
                             lztr_pkg::OFFS_SAT : alu_y[15:0];
                    len7 = {1'b0, raw_reg} + lztr_pkg::LEN_BASE_NEW
                         + 7'(dist16 > lztr_pkg::BONUS_LARGE)
                         + 7'(dist16 > lztr_pkg::BONUS_SMALL);
                    rep_next[3] = rep_reg[2];
                    rep_next[2] = rep_reg[1];
                    rep_next[1] = rep_reg[0];
                end else begin
                    dist16 = rep_reg[sel_reg[1:0]];
                    len7   = {1'b0, raw_reg} + lztr_pkg::LEN_BASE_REP;
                    if (sel_reg[1:0] == 2'd3) begin
                        rep_next[3] = rep_reg[2];
                    end
                    if (sel_reg[1:0] >= 2'd2) begin
                        rep_next[2] = rep_reg[1];
                    end
                    if (sel_reg[1:0] >= 2'd1) begin
                        rep_next[1] = rep_reg[0];
                    end
                end
                rep_next[0] = dist16;
                work_next   = DW'(dist16);
                len_next    = (len7 > 7'(MAX_MATCH)) ? LW'(MAX_MATCH) : LW'(len7);
                cnt_next    = '0;
                state_next  = lztr_pkg::ST_REDUCE;
            end
            lztr_pkg::ST_REDUCE: begin
                // distance modulo window by repeated subtraction
                alu_a = work_reg;
                alu_b = WIN_D;
                if (!alu_borrow) begin
                    work_next = alu_y;
                end else begin
                    state_next = lztr_pkg::ST_ADDR;
                end
            end
            lztr_pkg::ST_ADDR: begin
                alu_a = DW'(wp_reg);
                alu_b = work_reg;
                if (alu_borrow) begin
                    work_next  = alu_y;
                    state_next = lztr_pkg::ST_WRAP;
                end else begin
                    src_next   = alu_y[AW-1:0];
                    state_next = lztr_pkg::ST_READ;
                end
            end
            lztr_pkg::ST_WRAP: begin
                alu_op     = lztr_pkg::ALU_ADD;
                alu_a      = work_reg;
                alu_b      = WIN_D;
                src_next   = alu_y[AW-1:0];
                state_next = lztr_pkg::ST_READ;
            end
            lztr_pkg::ST_READ: begin
                ram_re     = 1'b1;
                state_next = lztr_pkg::ST_DATA;
            end
            lztr_pkg::ST_DATA: begin
                // copy one byte forward and emit it
                if (slot_free) begin
                    ram_we       = 1'b1;
                    ram_wdata    = ram_rdata;
                    m_valid_next = 1'b1;
                    byte_next    = ram_rdata;
                    last_next    = last_hit;
                    full_next    = full_hit;
                    wp_next      = wp_inc;
                    pos_next     = pos_inc;
                    src_next     = src_inc;
                    cnt_next     = cnt_inc;
                    state_next   = last_hit ? lztr_pkg::ST_IDLE : lztr_pkg::ST_READ;
                end
            end
            default: state_next = lztr_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lztr_pkg::ST_IDLE;
            wp_reg      <= '0;
            pos_reg     <= '0;
            limit_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                rep_reg[i] <= lztr_pkg::REP_RESET;
            end
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            pos_reg     <= pos_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
            rep_reg     <= rep_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        lit_reg  <= lit_next;
        sel_reg  <= sel_next;
        raw_reg  <= raw_next;
        len_reg  <= len_next;
        cnt_reg  <= cnt_next;
        work_reg <= work_next;
        src_reg  <= src_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        full_reg <= full_next;
    end

    assign s_ready        = state_reg == lztr_pkg::ST_IDLE;
    assign m_valid        = m_valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_last_of_item = last_reg;
    assign m_chunk_full   = full_reg;

    // position never runs past the chunk limit
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= limit_reg)
        else $error("chunk position beyond limit");

    // copy counter stays below the match length while copying
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lztr_pkg::ST_READ || state_reg == lztr_pkg::ST_DATA)
        |-> cnt_reg < len_reg)
        else $error("copy counter reached match length");

    // the byte that fills the chunk always closes its token
    a_full_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_chunk_full |-> m_last_of_item)
        else $error("chunk full without last flag");

    // a token in a full chunk leaves the sequencer idle
    a_ignore: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !active && s_opcode != lztr_pkg::OP_START
        |=> state_reg == lztr_pkg::ST_IDLE && $stable(wp_reg))
        else $error("ignored token changed state");

endmodule
